### rtl/tpc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and the cosine table for the triangle property unit.
// No dependencies; used by the channel interfaces, the top level and the checker.
package tpc_pkg;

    // Field widths
    localparam int SIDE_W    = 16;
    localparam int PER_W     = 18;
    localparam int AREA_W    = 33;
    localparam int HGT_W     = 18;
    localparam int ANG_W     = 8;
    localparam int FLG_W     = 3;
    localparam int FRAC_BITS = 2;

    // Shape flag positions
    localparam int FLG_EQU   = 0;
    localparam int FLG_ISO   = 1;
    localparam int FLG_RIGHT = 2;

    // Angle indexes
    localparam int N_ANG  = 3;
    localparam int ANG_AB = 0;
    localparam int ANG_AC = 1;
    localparam int ANG_BC = 2;

    // Internal widths
    localparam int DIFF_W   = SIDE_W + 1;
    localparam int M1_W     = PER_W + DIFF_W;
    localparam int M2_W     = 2 * DIFF_W;
    localparam int SPLIT_W  = DIFF_W;
    localparam int PL_W     = SPLIT_W + M2_W;
    localparam int PH_W     = (M1_W - SPLIT_W) + M2_W;
    localparam int P_W      = M1_W + M2_W;
    localparam int Q_W      = P_W + 2 * FRAC_BITS;
    localparam int RT_W     = (Q_W + 1) / 2;
    localparam int REM_W    = Q_W + 1;
    localparam int SQ_W     = 2 * SIDE_W;
    localparam int NUM_W    = SQ_W + 2;
    localparam int DEN_W    = SQ_W + 1;
    localparam int AREA_SHIFT = 2;
    localparam int HGT_SHIFT  = 1;
    localparam int DRW      = RT_W - HGT_SHIFT;
    localparam int DCMP_W   = DRW + SIDE_W;

    // Cosine table, unsigned Q30, one entry per whole degree up to a right angle
    localparam int ANG_MAX   = 180;
    localparam int ANG_RIGHT = 90;
    localparam int ANG_EQU   = 60;
    localparam int COS_FRAC  = 30;
    localparam int COS_W     = COS_FRAC + 1;
    localparam int COS_IDX_W = 7;
    localparam int PRD_W     = COS_W + DEN_W + 2;

    typedef logic [COS_W-1:0] t_cos_tab [0:ANG_RIGHT];
    typedef logic [63:0] t_taylor_div [1:14];

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_Q60 = PI_Q60 / 180;
    localparam logic [63:0] ONE_Q60 = 64'h1 << 60;
    localparam t_taylor_div TAYLOR_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                           64'd132, 64'd182, 64'd240, 64'd306, 64'd380,
                                           64'd462, 64'd552, 64'd650, 64'd756};

    function automatic logic [63:0] mul_q60(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = 128'(x) * 128'(y);
        return p[123:60];
    endfunction

    // Taylor series in Q60, rounded to Q30; evaluated at elaboration only
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab           tab;
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        for (int k = 0; k <= ANG_RIGHT; k++) begin
            t    = DEG_Q60 * 64'(k);
            t2   = mul_q60(t, t);
            term = ONE_Q60;
            acc  = signed'(ONE_Q60);
            for (int n = 1; n <= 14; n++) begin
                term = mul_q60(term, t2) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    acc = acc - signed'(term);
                end else begin
                    acc = acc + signed'(term);
                end
            end
            if (acc < 0) begin
                acc = '0;
            end
            tab[k] = COS_W'((64'(acc) + (64'h1 << (COS_FRAC - 1))) >> COS_FRAC);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

    // Signed cosine of a whole-degree angle, zero beyond a straight angle
    function automatic logic signed [COS_W:0] cos_signed(input logic [ANG_W-1:0] k);
        logic signed [COS_W:0] v;
        if (k > ANG_W'(ANG_MAX)) begin
            v = '0;
        end else if (k <= ANG_W'(ANG_RIGHT)) begin
            v = signed'({1'b0, COS_TAB[COS_IDX_W'(k)]});
        end else begin
            v = -signed'({1'b0, COS_TAB[COS_IDX_W'(ANG_W'(ANG_MAX) - k)]});
        end
        return v;
    endfunction

endpackage

### rtl/tpc_side_if.sv
`timescale 1ns / 1ps
// Request channel carrying one triple of side lengths.
// Depends on tpc_pkg.
interface tpc_side_if;
    logic                        valid;
    logic                        ready;
    logic [tpc_pkg::SIDE_W-1:0]  side_a;
    logic [tpc_pkg::SIDE_W-1:0]  side_b;
    logic [tpc_pkg::SIDE_W-1:0]  side_c;

    modport source (output valid, output side_a, output side_b, output side_c, input ready);
    modport sink   (input valid, input side_a, input side_b, input side_c, output ready);
endinterface

### rtl/tpc_res_if.sv
`timescale 1ns / 1ps
// Result channel carrying the properties of one triangle.
// Depends on tpc_pkg.
interface tpc_res_if;
    logic                        valid;
    logic                        ready;
    logic                        valid_res;
    logic [tpc_pkg::PER_W-1:0]   perimeter_sum;
    logic [tpc_pkg::AREA_W-1:0]  area_q2;
    logic [tpc_pkg::ANG_W-1:0]   angle_ab;
    logic [tpc_pkg::ANG_W-1:0]   angle_ac;
    logic [tpc_pkg::ANG_W-1:0]   angle_bc;
    logic [tpc_pkg::HGT_W-1:0]   height_on_a;
    logic [tpc_pkg::HGT_W-1:0]   height_on_b;
    logic [tpc_pkg::HGT_W-1:0]   height_on_c;
    logic [tpc_pkg::FLG_W-1:0]   shape_flags;

    modport source (output valid, output valid_res, output perimeter_sum, output area_q2,
                    output angle_ab, output angle_ac, output angle_bc, output height_on_a,
                    output height_on_b, output height_on_c, output shape_flags,
                    input ready);
    modport sink   (input valid, input valid_res, input perimeter_sum, input area_q2,
                    input angle_ab, input angle_ac, input angle_bc, input height_on_a,
                    input height_on_b, input height_on_c, input shape_flags,
                    output ready);
endinterface

### rtl/triangle_properties_calc.sv
`timescale 1ns / 1ps
// Triangle property unit: validity, perimeter, area, heights, angles, shape flags.
// Depends on tpc_pkg, tpc_side_if and tpc_res_if.
//
// Usage
//   i_side carries one request of three unsigned side lengths; o_res returns one
//   result per request, in order. Both use valid/ready; a transfer happens on a
//   rising edge with valid and ready high.
//   A request enters the input stage at the accepting edge and then passes two multiply
//   stages, a sum stage, 37 square-root stages (one root bit each, the angle searches
//   run in the first eight of them), 18 height divider stages (one quotient bit each)
//   and the output register, which drives o_res.
//   Throughput is one request per cycle while o_res is not stalled; every stage advances together.
//   When o_res holds a result that is not taken, the whole pipeline holds and
//   i_side.ready is low; nothing is dropped or repeated. Empty stages carry a
//   cleared valid bit.
//   Reset (i_rst_n low at a clock edge) clears all valid bits; no result is
//   pending afterwards. Payload registers are not reset.
//   Invalid triangles return valid_res low and every other field zero.
module triangle_properties_calc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpc_side_if.sink    i_side,
    tpc_res_if.source   o_res
);

    localparam int ST_MUL  = 1;
    localparam int ST_PART = 2;
    localparam int ST_SUM  = 3;
    localparam int ST_ROOT = 4;
    localparam int ST_DIV  = ST_ROOT + tpc_pkg::RT_W;
    localparam int ST_OUT  = ST_DIV + tpc_pkg::HGT_W;

    typedef struct packed {
        logic                                                   ok;
        logic [tpc_pkg::SIDE_W-1:0]                             a;
        logic [tpc_pkg::SIDE_W-1:0]                             b;
        logic [tpc_pkg::SIDE_W-1:0]                             c;
        logic [tpc_pkg::PER_W-1:0]                              per;
        logic [tpc_pkg::DIFF_W-1:0]                             x;
        logic [tpc_pkg::DIFF_W-1:0]                             y;
        logic [tpc_pkg::DIFF_W-1:0]                             z;
        logic                                                   equ;
        logic                                                   iso;
        logic                                                   right;
        logic [tpc_pkg::M1_W-1:0]                               m1;
        logic [tpc_pkg::M2_W-1:0]                               m2;
        logic [tpc_pkg::SQ_W-1:0]                               sq_a;
        logic [tpc_pkg::SQ_W-1:0]                               sq_b;
        logic [tpc_pkg::SQ_W-1:0]                               sq_c;
        logic [tpc_pkg::SQ_W-1:0]                               pr_ab;
        logic [tpc_pkg::SQ_W-1:0]                               pr_ac;
        logic [tpc_pkg::SQ_W-1:0]                               pr_bc;
        logic [tpc_pkg::PL_W-1:0]                               pl;
        logic [tpc_pkg::PH_W-1:0]                               ph;
        logic [tpc_pkg::N_ANG-1:0][tpc_pkg::NUM_W-1:0]          num;
        logic [tpc_pkg::N_ANG-1:0][tpc_pkg::DEN_W-1:0]          den;
        logic [tpc_pkg::N_ANG-1:0][tpc_pkg::ANG_W-1:0]          deg;
        logic [tpc_pkg::REM_W-1:0]                              rem;
        logic [tpc_pkg::RT_W-1:0]                               root;
        logic [tpc_pkg::N_ANG-1:0][tpc_pkg::DRW-1:0]            drem;
        logic [tpc_pkg::N_ANG-1:0][tpc_pkg::HGT_W-1:0]          quo;
        logic [tpc_pkg::N_ANG-1:0]                              sat;
    } t_pipe;

    typedef struct packed {
        logic                         valid_res;
        logic [tpc_pkg::PER_W-1:0]    perimeter_sum;
        logic [tpc_pkg::AREA_W-1:0]   area_q2;
        logic [tpc_pkg::ANG_W-1:0]    angle_ab;
        logic [tpc_pkg::ANG_W-1:0]    angle_ac;
        logic [tpc_pkg::ANG_W-1:0]    angle_bc;
        logic [tpc_pkg::HGT_W-1:0]    height_on_a;
        logic [tpc_pkg::HGT_W-1:0]    height_on_b;
        logic [tpc_pkg::HGT_W-1:0]    height_on_c;
        logic [tpc_pkg::FLG_W-1:0]    shape_flags;
    } t_res;

    t_pipe                r_pipe [ST_OUT];
    t_pipe                n_pipe [ST_OUT];
    logic [ST_OUT-1:0]    r_v;
    t_res                 r_res;
    t_res                 n_res;
    logic                 r_out_v;
    logic                 en;

    // Advance everything unless a finished result is waiting
    assign en           = !r_out_v || o_res.ready;
    assign i_side.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v     <= {r_v[ST_OUT-2:0], i_side.valid};
            r_out_v <= r_v[ST_OUT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < ST_OUT; s++) begin
                r_pipe[s] <= n_pipe[s];
            end
            r_res <= n_res;
        end
    end

    // Input stage: validity, perimeter, Heron factors, equality flags
    always_comb begin
        n_pipe[0]     = '0;
        n_pipe[0].a   = i_side.side_a;
        n_pipe[0].b   = i_side.side_b;
        n_pipe[0].c   = i_side.side_c;
        n_pipe[0].ok  = (i_side.side_a != '0) && (i_side.side_b != '0)
                     && (i_side.side_c != '0)
                     && ({1'b0, i_side.side_a} + {1'b0, i_side.side_b} > {1'b0, i_side.side_c})
                     && ({1'b0, i_side.side_a} + {1'b0, i_side.side_c} > {1'b0, i_side.side_b})
                     && ({1'b0, i_side.side_b} + {1'b0, i_side.side_c} > {1'b0, i_side.side_a});
        n_pipe[0].per = tpc_pkg::PER_W'(i_side.side_a) + tpc_pkg::PER_W'(i_side.side_b)
                      + tpc_pkg::PER_W'(i_side.side_c);
        n_pipe[0].x   = {1'b0, i_side.side_b} + {1'b0, i_side.side_c} - {1'b0, i_side.side_a};
        n_pipe[0].y   = {1'b0, i_side.side_a} + {1'b0, i_side.side_c} - {1'b0, i_side.side_b};
        n_pipe[0].z   = {1'b0, i_side.side_a} + {1'b0, i_side.side_b} - {1'b0, i_side.side_c};
        n_pipe[0].equ = (i_side.side_a == i_side.side_b) && (i_side.side_b == i_side.side_c);
        n_pipe[0].iso = (i_side.side_a == i_side.side_b) || (i_side.side_a == i_side.side_c)
                     || (i_side.side_b == i_side.side_c);
    end

    for (genvar s = 1; s < ST_OUT; s++) begin : g_stg
        if (s == ST_MUL) begin : g_mul
            always_comb begin
                n_pipe[s]       = r_pipe[s-1];
                n_pipe[s].m1    = tpc_pkg::M1_W'(r_pipe[s-1].per) * tpc_pkg::M1_W'(r_pipe[s-1].x);
                n_pipe[s].m2    = tpc_pkg::M2_W'(r_pipe[s-1].y) * tpc_pkg::M2_W'(r_pipe[s-1].z);
                n_pipe[s].sq_a  = tpc_pkg::SQ_W'(r_pipe[s-1].a) * tpc_pkg::SQ_W'(r_pipe[s-1].a);
                n_pipe[s].sq_b  = tpc_pkg::SQ_W'(r_pipe[s-1].b) * tpc_pkg::SQ_W'(r_pipe[s-1].b);
                n_pipe[s].sq_c  = tpc_pkg::SQ_W'(r_pipe[s-1].c) * tpc_pkg::SQ_W'(r_pipe[s-1].c);
                n_pipe[s].pr_ab = tpc_pkg::SQ_W'(r_pipe[s-1].a) * tpc_pkg::SQ_W'(r_pipe[s-1].b);
                n_pipe[s].pr_ac = tpc_pkg::SQ_W'(r_pipe[s-1].a) * tpc_pkg::SQ_W'(r_pipe[s-1].c);
                n_pipe[s].pr_bc = tpc_pkg::SQ_W'(r_pipe[s-1].b) * tpc_pkg::SQ_W'(r_pipe[s-1].c);
            end
        end else if (s == ST_PART) begin : g_part
            always_comb begin
                n_pipe[s]    = r_pipe[s-1];
                // Split the wide Heron product into two partial products
                n_pipe[s].pl = tpc_pkg::PL_W'(r_pipe[s-1].m1[tpc_pkg::SPLIT_W-1:0])
                             * tpc_pkg::PL_W'(r_pipe[s-1].m2);
                n_pipe[s].ph = tpc_pkg::PH_W'(r_pipe[s-1].m1[tpc_pkg::M1_W-1:tpc_pkg::SPLIT_W])
                             * tpc_pkg::PH_W'(r_pipe[s-1].m2);
                n_pipe[s].num[tpc_pkg::ANG_AB] = tpc_pkg::NUM_W'(r_pipe[s-1].sq_a)
                    + tpc_pkg::NUM_W'(r_pipe[s-1].sq_b) - tpc_pkg::NUM_W'(r_pipe[s-1].sq_c);
                n_pipe[s].num[tpc_pkg::ANG_AC] = tpc_pkg::NUM_W'(r_pipe[s-1].sq_a)
                    + tpc_pkg::NUM_W'(r_pipe[s-1].sq_c) - tpc_pkg::NUM_W'(r_pipe[s-1].sq_b);
                n_pipe[s].num[tpc_pkg::ANG_BC] = tpc_pkg::NUM_W'(r_pipe[s-1].sq_b)
                    + tpc_pkg::NUM_W'(r_pipe[s-1].sq_c) - tpc_pkg::NUM_W'(r_pipe[s-1].sq_a);
                n_pipe[s].den[tpc_pkg::ANG_AB] = {r_pipe[s-1].pr_ab, 1'b0};
                n_pipe[s].den[tpc_pkg::ANG_AC] = {r_pipe[s-1].pr_ac, 1'b0};
                n_pipe[s].den[tpc_pkg::ANG_BC] = {r_pipe[s-1].pr_bc, 1'b0};
                n_pipe[s].deg   = '0;
                n_pipe[s].right =
                    ({1'b0, r_pipe[s-1].sq_a} + {1'b0, r_pipe[s-1].sq_b} == {1'b0, r_pipe[s-1].sq_c})
                 || ({1'b0, r_pipe[s-1].sq_a} + {1'b0, r_pipe[s-1].sq_c} == {1'b0, r_pipe[s-1].sq_b})
                 || ({1'b0, r_pipe[s-1].sq_b} + {1'b0, r_pipe[s-1].sq_c} == {1'b0, r_pipe[s-1].sq_a});
            end
        end else if (s == ST_SUM) begin : g_sum
            logic [tpc_pkg::P_W-1:0] prod;
            always_comb begin
                n_pipe[s]      = r_pipe[s-1];
                prod           = tpc_pkg::P_W'(r_pipe[s-1].pl)
                               + (tpc_pkg::P_W'(r_pipe[s-1].ph) << tpc_pkg::SPLIT_W);
                n_pipe[s].rem  = tpc_pkg::REM_W'(prod) << (2 * tpc_pkg::FRAC_BITS);
                n_pipe[s].root = '0;
            end
        end else if (s < ST_DIV) begin : g_root
            localparam int  RB     = tpc_pkg::RT_W - 1 - (s - ST_ROOT);
            localparam bit  DO_ANG = (s - ST_ROOT) < tpc_pkg::ANG_W;
            localparam int  AB     = DO_ANG ? (tpc_pkg::ANG_W - 1 - (s - ST_ROOT)) : 0;
            logic [tpc_pkg::REM_W-1:0]                       trial;
            logic [tpc_pkg::N_ANG-1:0][tpc_pkg::ANG_W-1:0]   cand;
            logic signed [tpc_pkg::COS_W:0]                  sc  [tpc_pkg::N_ANG];
            logic signed [tpc_pkg::PRD_W-1:0]                lhs [tpc_pkg::N_ANG];
            logic signed [tpc_pkg::PRD_W-1:0]                rhs [tpc_pkg::N_ANG];
            always_comb begin
                n_pipe[s] = r_pipe[s-1];
                // One root bit: accept it if (root + bit)^2 still fits under q
                trial = (tpc_pkg::REM_W'(r_pipe[s-1].root) << (RB + 1))
                      + (tpc_pkg::REM_W'(1) << (2 * RB));
                if (r_pipe[s-1].rem >= trial) begin
                    n_pipe[s].rem      = r_pipe[s-1].rem - trial;
                    n_pipe[s].root[RB] = 1'b1;
                end
                // One degree bit per angle: keep it if cos(candidate) is still >= ratio
                for (int k = 0; k < tpc_pkg::N_ANG; k++) begin
                    cand[k] = r_pipe[s-1].deg[k] | (tpc_pkg::ANG_W'(1) << AB);
                    sc[k]   = tpc_pkg::cos_signed(cand[k]);
                    lhs[k]  = tpc_pkg::PRD_W'(signed'(r_pipe[s-1].num[k])) <<< tpc_pkg::COS_FRAC;
                    rhs[k]  = tpc_pkg::PRD_W'(sc[k])
                            * $signed(tpc_pkg::PRD_W'(r_pipe[s-1].den[k]));
                    if (DO_ANG && (cand[k] <= tpc_pkg::ANG_W'(tpc_pkg::ANG_MAX))
                            && (lhs[k] <= rhs[k])) begin
                        n_pipe[s].deg[k] = cand[k];
                    end
                end
            end
        end else begin : g_div
            localparam int J = tpc_pkg::HGT_W - 1 - (s - ST_DIV);
            logic [tpc_pkg::N_ANG-1:0][tpc_pkg::SIDE_W-1:0] sd;
            logic [tpc_pkg::DCMP_W-1:0]                     rm [tpc_pkg::N_ANG];
            logic [tpc_pkg::DCMP_W-1:0]                     dv [tpc_pkg::N_ANG];
            always_comb begin
                n_pipe[s] = r_pipe[s-1];
                sd[0]     = r_pipe[s-1].a;
                sd[1]     = r_pipe[s-1].b;
                sd[2]     = r_pipe[s-1].c;
                for (int k = 0; k < tpc_pkg::N_ANG; k++) begin
                    if (s == ST_DIV) begin
                        // Twice the area over the side: start from root/2, flag overflow
                        rm[k] = tpc_pkg::DCMP_W'(r_pipe[s-1].root[tpc_pkg::RT_W-1:tpc_pkg::HGT_SHIFT]);
                        n_pipe[s].sat[k] = rm[k] >= (tpc_pkg::DCMP_W'(sd[k]) << tpc_pkg::HGT_W);
                        n_pipe[s].quo[k] = '0;
                    end else begin
                        rm[k] = tpc_pkg::DCMP_W'(r_pipe[s-1].drem[k]);
                    end
                    dv[k] = tpc_pkg::DCMP_W'(sd[k]) << J;
                    if (rm[k] >= dv[k]) begin
                        rm[k]               = rm[k] - dv[k];
                        n_pipe[s].quo[k][J] = 1'b1;
                    end
                    n_pipe[s].drem[k] = tpc_pkg::DRW'(rm[k]);
                end
            end
        end
    end

    // Output stage: saturate, zero invalid triangles
    logic [tpc_pkg::RT_W-tpc_pkg::AREA_SHIFT-1:0] area_full;
    assign area_full = r_pipe[ST_OUT-1].root[tpc_pkg::RT_W-1:tpc_pkg::AREA_SHIFT];

    always_comb begin
        n_res = '0;
        if (r_pipe[ST_OUT-1].ok) begin
            n_res.valid_res     = 1'b1;
            n_res.perimeter_sum = r_pipe[ST_OUT-1].per;
            n_res.area_q2       = (area_full >
                                  (tpc_pkg::RT_W - tpc_pkg::AREA_SHIFT)'({tpc_pkg::AREA_W{1'b1}}))
                                ? '1 : tpc_pkg::AREA_W'(area_full);
            n_res.angle_ab      = r_pipe[ST_OUT-1].deg[tpc_pkg::ANG_AB];
            n_res.angle_ac      = r_pipe[ST_OUT-1].deg[tpc_pkg::ANG_AC];
            n_res.angle_bc      = r_pipe[ST_OUT-1].deg[tpc_pkg::ANG_BC];
            n_res.height_on_a   = r_pipe[ST_OUT-1].sat[0] ? '1 : r_pipe[ST_OUT-1].quo[0];
            n_res.height_on_b   = r_pipe[ST_OUT-1].sat[1] ? '1 : r_pipe[ST_OUT-1].quo[1];
            n_res.height_on_c   = r_pipe[ST_OUT-1].sat[2] ? '1 : r_pipe[ST_OUT-1].quo[2];
            n_res.shape_flags[tpc_pkg::FLG_EQU]   = r_pipe[ST_OUT-1].equ;
            n_res.shape_flags[tpc_pkg::FLG_ISO]   = r_pipe[ST_OUT-1].iso;
            n_res.shape_flags[tpc_pkg::FLG_RIGHT] = r_pipe[ST_OUT-1].right;
        end
    end

    assign o_res.valid         = r_out_v;
    assign o_res.valid_res     = r_res.valid_res;
    assign o_res.perimeter_sum = r_res.perimeter_sum;
    assign o_res.area_q2       = r_res.area_q2;
    assign o_res.angle_ab      = r_res.angle_ab;
    assign o_res.angle_ac      = r_res.angle_ac;
    assign o_res.angle_bc      = r_res.angle_bc;
    assign o_res.height_on_a   = r_res.height_on_a;
    assign o_res.height_on_b   = r_res.height_on_b;
    assign o_res.height_on_c   = r_res.height_on_c;
    assign o_res.shape_flags   = r_res.shape_flags;

endmodule

### rtl/tpc_check.sv
`timescale 1ns / 1ps
// Port-level checks for the triangle property unit, bound to the top level.
// Depends on tpc_pkg and triangle_properties_calc.
module tpc_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_valid_res,
    input logic [tpc_pkg::PER_W-1:0]   i_perimeter_sum,
    input logic [tpc_pkg::AREA_W-1:0]  i_area_q2,
    input logic [tpc_pkg::ANG_W-1:0]   i_angle_ab,
    input logic [tpc_pkg::ANG_W-1:0]   i_angle_ac,
    input logic [tpc_pkg::ANG_W-1:0]   i_angle_bc,
    input logic [tpc_pkg::HGT_W-1:0]   i_height_on_a,
    input logic [tpc_pkg::FLG_W-1:0]   i_shape_flags
);

    // A result not taken stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_perimeter_sum)
            && $stable(i_area_q2) && $stable(i_angle_ab) && $stable(i_shape_flags))
        else $error("result changed while stalled");

    // A stalled result stops new requests
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("request taken while output stalled");

    // Invalid triangle gives an all-zero result
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_valid_res |-> (i_perimeter_sum == '0) && (i_area_q2 == '0)
            && (i_angle_ab == '0) && (i_height_on_a == '0) && (i_shape_flags == '0))
        else $error("invalid triangle with nonzero fields");

    // Equilateral: isosceles too, all angles sixty degrees
    a_equ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_valid_res && i_shape_flags[tpc_pkg::FLG_EQU] |->
            i_shape_flags[tpc_pkg::FLG_ISO]
            && (i_angle_ab == tpc_pkg::ANG_W'(tpc_pkg::ANG_EQU))
            && (i_angle_ac == tpc_pkg::ANG_W'(tpc_pkg::ANG_EQU))
            && (i_angle_bc == tpc_pkg::ANG_W'(tpc_pkg::ANG_EQU)))
        else $error("equilateral result inconsistent");

    // Right-angled: one angle is exactly ninety degrees
    a_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_valid_res && i_shape_flags[tpc_pkg::FLG_RIGHT] |->
            (i_angle_ab == tpc_pkg::ANG_W'(tpc_pkg::ANG_RIGHT))
            || (i_angle_ac == tpc_pkg::ANG_W'(tpc_pkg::ANG_RIGHT))
            || (i_angle_bc == tpc_pkg::ANG_W'(tpc_pkg::ANG_RIGHT)))
        else $error("right flag without a right angle");

endmodule

bind triangle_properties_calc tpc_check u_tpc_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_side.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_valid_res     (o_res.valid_res),
    .i_perimeter_sum (o_res.perimeter_sum),
    .i_area_q2       (o_res.area_q2),
    .i_angle_ab      (o_res.angle_ab),
    .i_angle_ac      (o_res.angle_ac),
    .i_angle_bc      (o_res.angle_bc),
    .i_height_on_a   (o_res.height_on_a),
    .i_shape_flags   (o_res.shape_flags)
);

### sim/triangle_properties_calc_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the triangle property unit: directed and random side triples,
// bursty requests and a stalling result receiver, each result checked against a predictor.
// Depends on tpc_pkg, tpc_side_if, tpc_res_if and triangle_properties_calc.
module triangle_properties_calc_test;

    typedef logic signed [127:0] t_s128;

    typedef struct packed {
        logic                          valid_res;
        logic [tpc_pkg::PER_W-1:0]     perimeter_sum;
        logic [tpc_pkg::AREA_W-1:0]    area_q2;
        logic [tpc_pkg::ANG_W-1:0]     angle_ab;
        logic [tpc_pkg::ANG_W-1:0]     angle_ac;
        logic [tpc_pkg::ANG_W-1:0]     angle_bc;
        logic [tpc_pkg::HGT_W-1:0]     height_on_a;
        logic [tpc_pkg::HGT_W-1:0]     height_on_b;
        logic [tpc_pkg::HGT_W-1:0]     height_on_c;
        logic [tpc_pkg::FLG_W-1:0]     shape_flags;
    } t_tri_props;

    localparam int RUN_ITEMS   = 1950;
    localparam int LATENCY     = 60;
    localparam int CYCLE_LIMIT = 600000;

    // Receiver behaviour phases
    localparam int STALL_NONE    = 0;
    localparam int STALL_RANDOM  = 1;
    localparam int STALL_PATTERN = 2;

    class tri_scoreboard;
        t_tri_props pending[$];
        int         errors = 0;

        function void note(t_tri_props props);
            pending.push_back(props);
        endfunction

        task report(string what, longint got, longint want);
            $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
            errors++;
        endtask

        task check(t_tri_props got);
            t_tri_props want;
            if (pending.size() == 0) begin
                report("result with none pending", longint'(got.perimeter_sum), 64'sd0);
                return;
            end
            want = pending.pop_front();
            if (got.valid_res !== want.valid_res)
                report("valid_res", longint'(got.valid_res), longint'(want.valid_res));
            if (got.perimeter_sum !== want.perimeter_sum)
                report("perimeter_sum", longint'(got.perimeter_sum),
                       longint'(want.perimeter_sum));
            if (got.area_q2 !== want.area_q2)
                report("area_q2", longint'(got.area_q2), longint'(want.area_q2));
            if (got.angle_ab !== want.angle_ab)
                report("angle_ab", longint'(got.angle_ab), longint'(want.angle_ab));
            if (got.angle_ac !== want.angle_ac)
                report("angle_ac", longint'(got.angle_ac), longint'(want.angle_ac));
            if (got.angle_bc !== want.angle_bc)
                report("angle_bc", longint'(got.angle_bc), longint'(want.angle_bc));
            if (got.height_on_a !== want.height_on_a)
                report("height_on_a", longint'(got.height_on_a), longint'(want.height_on_a));
            if (got.height_on_b !== want.height_on_b)
                report("height_on_b", longint'(got.height_on_b), longint'(want.height_on_b));
            if (got.height_on_c !== want.height_on_c)
                report("height_on_c", longint'(got.height_on_c), longint'(want.height_on_c));
            if (got.shape_flags !== want.shape_flags)
                report("shape_flags", longint'(got.shape_flags), longint'(want.shape_flags));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    tpc_side_if side_ch();
    tpc_res_if  res_ch();

    triangle_properties_calc uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (side_ch.sink),
        .o_res   (res_ch.source)
    );

    tri_scoreboard board = new();
    logic [tpc_pkg::COS_W-1:0] cos_q30 [0:tpc_pkg::ANG_RIGHT];
    int unsigned cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic logic [63:0] q60_product(logic [63:0] x, logic [63:0] y);
        logic [127:0] pr;
        pr = {64'd0, x} * {64'd0, y};
        return pr[123:60];
    endfunction

    // Taylor series of cos in Q60, rounded to Q30
    function automatic void fill_cos_table();
        logic [63:0] step, t, t2, term;
        longint      acc;
        step = 64'h3243F6A8885A308D / 64'd180;
        for (int k = 0; k <= tpc_pkg::ANG_RIGHT; k++) begin
            t    = step * 64'(k);
            t2   = q60_product(t, t);
            term = 64'h1 << 60;
            acc  = longint'(64'h1 << 60);
            for (int n = 1; n <= 14; n++) begin
                term = q60_product(term, t2) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) acc = acc - longint'(term);
                else            acc = acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            cos_q30[k] = tpc_pkg::COS_W'((64'(acc) + (64'h1 << 29)) >> 30);
        end
    endfunction

    function automatic logic [63:0] root_of(logic [127:0] v);
        logic [63:0] r, trial;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = r | (64'h1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= v) r = trial;
        end
        return r;
    endfunction

    // count of whole degrees k with (p^2+q^2-r^2)/(2pq) <= cos k
    function automatic logic [tpc_pkg::ANG_W-1:0] angle_between(
            logic [tpc_pkg::SIDE_W-1:0] p, q, r);
        longint num, den;
        t_s128  lhs, cs;
        int     deg;
        num = longint'(p) * p + longint'(q) * q - longint'(r) * r;
        den = 2 * longint'(p) * q;
        lhs = t_s128'(num) <<< 30;
        deg = 0;
        for (int k = 1; k <= tpc_pkg::ANG_MAX; k++) begin
            cs = (k <= tpc_pkg::ANG_RIGHT) ? t_s128'(cos_q30[k])
                                           : -t_s128'(cos_q30[tpc_pkg::ANG_MAX - k]);
            if (lhs <= cs * t_s128'(den)) deg++;
        end
        return tpc_pkg::ANG_W'(deg);
    endfunction

    function automatic logic [tpc_pkg::HGT_W-1:0] height_from(logic [63:0] root2,
                                                              logic [tpc_pkg::SIDE_W-1:0] s);
        logic [63:0] h;
        h = (root2 >> 1) / 64'(s);
        return (h > 64'h3FFFF) ? '1 : tpc_pkg::HGT_W'(h);
    endfunction

    function automatic t_tri_props triangle_props(logic [tpc_pkg::SIDE_W-1:0] a, b, c);
        t_tri_props  o;
        logic [63:0] sa, sb, sc, per, root2, area;
        logic [127:0] heron;
        o = '0;
        sa = 64'(a); sb = 64'(b); sc = 64'(c);
        if (a == 0 || b == 0 || c == 0 || sa + sb <= sc || sa + sc <= sb || sb + sc <= sa)
            return o;
        per   = sa + sb + sc;
        heron = {64'd0, per * (sb + sc - sa)} * {64'd0, (sa + sc - sb) * (sa + sb - sc)};
        root2 = root_of(heron << (2 * tpc_pkg::FRAC_BITS));
        area  = root2 >> 2;
        o.valid_res     = 1'b1;
        o.perimeter_sum = tpc_pkg::PER_W'(per);
        o.area_q2       = (area > 64'h1FFFFFFFF) ? '1 : tpc_pkg::AREA_W'(area);
        o.angle_ab      = angle_between(a, b, c);
        o.angle_ac      = angle_between(a, c, b);
        o.angle_bc      = angle_between(b, c, a);
        o.height_on_a   = height_from(root2, a);
        o.height_on_b   = height_from(root2, b);
        o.height_on_c   = height_from(root2, c);
        o.shape_flags[tpc_pkg::FLG_EQU] = (a == b) && (b == c);
        o.shape_flags[tpc_pkg::FLG_ISO] = (a == b) || (a == c) || (b == c);
        o.shape_flags[tpc_pkg::FLG_RIGHT] = (sa * sa + sb * sb == sc * sc) ||
                                            (sa * sa + sc * sc == sb * sb) ||
                                            (sb * sb + sc * sc == sa * sa);
        return o;
    endfunction

    // ---------------------------------------------------------------- monitors
    always @(posedge i_clk) begin
        if (i_rst_n && side_ch.valid && side_ch.ready)
            board.note(triangle_props(side_ch.side_a, side_ch.side_b, side_ch.side_c));
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check({res_ch.valid_res, res_ch.perimeter_sum, res_ch.area_q2,
                         res_ch.angle_ab, res_ch.angle_ac, res_ch.angle_bc,
                         res_ch.height_on_a, res_ch.height_on_b, res_ch.height_on_c,
                         res_ch.shape_flags});
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stalls: phases of always ready, random stalls and a fixed pattern
    int stall_mode = STALL_NONE;
    int stall_left = 0;
    int stall_tick = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(STALL_PATTERN, STALL_NONE);
            stall_left = $urandom_range(300, 20);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE: begin
                res_ch.ready <= 1'b1;
            end
            STALL_RANDOM: begin
                res_ch.ready <= ($urandom % 4) != 0;
            end
            default: begin
                res_ch.ready <= (stall_tick % 7) >= 3;
            end
        endcase
    end

    // ---------------------------------------------------------------- stimulus
    task automatic send_request(logic [tpc_pkg::SIDE_W-1:0] a, b, c);
        side_ch.valid  <= 1'b1;
        side_ch.side_a <= a;
        side_ch.side_b <= b;
        side_ch.side_c <= c;
        do @(posedge i_clk); while (!side_ch.ready);
    endtask

    task automatic hold_off(int n);
        side_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_random_triangle();
        logic [tpc_pkg::SIDE_W-1:0] a, b, c, t;
        int unsigned lo, hi, k, pick, lim;
        pick = $urandom_range(99, 0);
        lim  = ($urandom_range(3, 0) == 0) ? 65535 : 64;
        a = tpc_pkg::SIDE_W'($urandom_range(lim, 1));
        b = tpc_pkg::SIDE_W'($urandom_range(lim, 1));
        if (pick < 60) begin
            lo = (a > b) ? a - b + 1 : b - a + 1;
            hi = (32'(a) + b - 1 > 65535) ? 65535 : 32'(a) + b - 1;
            c  = tpc_pkg::SIDE_W'($urandom_range(hi, lo));
        end else if (pick < 70) begin
            k = $urandom_range(13107, 1);
            {a, b, c} = {tpc_pkg::SIDE_W'(3 * k), tpc_pkg::SIDE_W'(4 * k),
                         tpc_pkg::SIDE_W'(5 * k)};
        end else if (pick < 80) begin
            c = a;
            if (pick < 74) b = a;
        end else if (pick < 88) begin
            c = ((32'(a) + b) > 65535) ? 16'hFFFF : a + b;
        end else begin
            a = tpc_pkg::SIDE_W'($urandom);
            b = tpc_pkg::SIDE_W'($urandom);
            c = tpc_pkg::SIDE_W'($urandom);
            if (pick < 91) a = 0;
        end
        case ($urandom_range(2, 0))
            0: begin t = a; a = c; c = t; end
            1: begin t = b; b = c; c = t; end
            default: ;
        endcase
        send_request(a, b, c);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        side_ch.valid  <= 1'b0;
        side_ch.side_a <= '0;
        side_ch.side_b <= '0;
        side_ch.side_c <= '0;
        fill_cos_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sides, degenerate, equilateral, isosceles, right, extremes
        send_request(0, 0, 0);
        send_request(0, 5, 5);
        send_request(7, 0, 7);
        send_request(65535, 65535, 0);
        send_request(1, 2, 3);
        send_request(1, 1, 2);
        send_request(65535, 1, 1);
        send_request(1, 1, 1);
        send_request(65535, 65535, 65535);
        send_request(3, 4, 5);
        send_request(5, 3, 4);
        send_request(4, 5, 3);
        send_request(39321, 52428, 65535);
        send_request(2, 2, 3);
        send_request(5, 5, 8);
        send_request(65535, 65535, 1);
        send_request(65535, 1, 65535);
        send_request(1, 65535, 65535);
        send_request(65534, 65535, 65535);
        send_request(32768, 32767, 65534);
        send_request(21845, 43690, 65534);
        hold_off(3);

        for (int n = 0; n < RUN_ITEMS; ) begin
            int burst;
            burst = $urandom_range(40, 1);
            for (int j = 0; j < burst; j++) send_random_triangle();
            n += burst;
            if ($urandom_range(5, 0) != 0) hold_off($urandom_range(20, 1));
        end
        side_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
